@@ hdl/vas_pkg.sv @@
// Shared types and constants of the voice activity segmenter.
package vas_pkg;

    // Default widths of sample times and of probabilities.
    localparam int TIME_BITS_DEFAULT = 32;
    localparam int PROB_BITS_DEFAULT = 16;

    // Width of the window length register.
    localparam int WINDOW_BITS = 13;

    // Configuration register indexes.
    localparam int CFG_ADDR_BITS = 3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPEECH_THRESHOLD     = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_WINDOW_SAMPLES       = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_SPEECH_SAMPLES   = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MIN_SILENCE_SAMPLES  = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_LONG_SILENCE_SAMPLES = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_SPEECH_SAMPLES   = 3'd5;

    // Register values after reset.
    localparam int THRESHOLD_RESET    = 32768;
    localparam int WINDOW_RESET       = 512;
    localparam int MIN_SPEECH_RESET   = 4000;
    localparam int MIN_SILENCE_RESET  = 1600;
    localparam int LONG_SILENCE_RESET = 1568;

    // Input command codes.
    localparam logic CMD_WINDOW = 1'b0;
    localparam logic CMD_END    = 1'b1;

    // Flags that accompany one result.
    typedef struct packed {
        logic segment_valid;
        logic voice_detected;
    } t_flags;

endpackage

@@ hdl/vas_core.sv @@
// Configuration registers, stream state and per-window segmentation decision.
module vas_core #(
    parameter int TIME_BITS = vas_pkg::TIME_BITS_DEFAULT,
    parameter int PROB_BITS = vas_pkg::PROB_BITS_DEFAULT,
    parameter int CFG_BITS  = vas_pkg::TIME_BITS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [vas_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_BITS-1:0]              i_cfg_wdata,
    input  logic                             i_step,
    input  logic                             i_command,
    input  logic [PROB_BITS-1:0]             i_speech_probability,
    input  logic [TIME_BITS-1:0]             i_total_samples,
    output vas_pkg::t_flags                  o_flags,
    output logic [TIME_BITS-1:0]             o_segment_start,
    output logic [TIME_BITS-1:0]             o_segment_end
);

    // Hysteresis gap of 0.15 in Q0.PROB_BITS, rounded down.
    localparam logic [PROB_BITS:0] LowGap = (PROB_BITS+1)'((15 << PROB_BITS) / 100);

    logic [PROB_BITS-1:0]            r_threshold;
    logic [vas_pkg::WINDOW_BITS-1:0] r_window;
    logic [TIME_BITS-1:0]            r_min_speech;
    logic [TIME_BITS-1:0]            r_min_silence;
    logic [TIME_BITS-1:0]            r_long_silence;
    logic [TIME_BITS-1:0]            r_max_speech;

    logic [TIME_BITS-1:0] r_count, n_count;
    logic                 r_in_speech, n_in_speech;
    logic [TIME_BITS-1:0] r_silence_start, n_silence_start;
    logic                 r_silence_pending, n_silence_pending;
    logic [TIME_BITS-1:0] r_split_end, n_split_end;
    logic                 r_split_valid, n_split_valid;
    logic [TIME_BITS-1:0] r_resume_start, n_resume_start;
    logic [TIME_BITS-1:0] r_open_start, n_open_start;
    logic                 r_segment_open, n_segment_open;

    logic [TIME_BITS-1:0] count_next;
    logic [TIME_BITS-1:0] sil_start;
    logic [TIME_BITS-1:0] sil_len;
    logic [TIME_BITS-1:0] seg_len;
    logic [TIME_BITS-1:0] speech_len;
    logic                 voice;
    logic                 silent;
    logic                 resume_early;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= PROB_BITS'(vas_pkg::THRESHOLD_RESET);
            r_window       <= vas_pkg::WINDOW_BITS'(vas_pkg::WINDOW_RESET);
            r_min_speech   <= TIME_BITS'(vas_pkg::MIN_SPEECH_RESET);
            r_min_silence  <= TIME_BITS'(vas_pkg::MIN_SILENCE_RESET);
            r_long_silence <= TIME_BITS'(vas_pkg::LONG_SILENCE_RESET);
            r_max_speech   <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                vas_pkg::CFG_SPEECH_THRESHOLD: begin
                    r_threshold <= i_cfg_wdata[PROB_BITS-1:0];
                end
                vas_pkg::CFG_WINDOW_SAMPLES: begin
                    r_window <= i_cfg_wdata[vas_pkg::WINDOW_BITS-1:0];
                end
                vas_pkg::CFG_MIN_SPEECH_SAMPLES: begin
                    r_min_speech <= i_cfg_wdata[TIME_BITS-1:0];
                end
                vas_pkg::CFG_MIN_SILENCE_SAMPLES: begin
                    r_min_silence <= i_cfg_wdata[TIME_BITS-1:0];
                end
                vas_pkg::CFG_LONG_SILENCE_SAMPLES: begin
                    r_long_silence <= i_cfg_wdata[TIME_BITS-1:0];
                end
                vas_pkg::CFG_MAX_SPEECH_SAMPLES: begin
                    r_max_speech <= i_cfg_wdata[TIME_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // The window that just arrived starts at the old count.
    assign count_next   = r_count + TIME_BITS'(r_window);
    assign voice        = i_speech_probability >= r_threshold;
    assign silent       = ({1'b0, i_speech_probability} + LowGap) < {1'b0, r_threshold};
    assign sil_start    = r_silence_pending ? r_silence_start : count_next;
    assign sil_len      = count_next - sil_start;
    assign seg_len      = count_next - r_open_start;
    assign speech_len   = sil_start - r_open_start;
    assign resume_early = r_resume_start < r_split_end;

    always_comb begin
        n_count           = r_count;
        n_in_speech       = r_in_speech;
        n_silence_start   = r_silence_start;
        n_silence_pending = r_silence_pending;
        n_split_end       = r_split_end;
        n_split_valid     = r_split_valid;
        n_resume_start    = r_resume_start;
        n_open_start      = r_open_start;
        n_segment_open    = r_segment_open;
        o_flags           = '0;
        o_segment_start   = '0;
        o_segment_end     = '0;

        if (i_command == vas_pkg::CMD_END) begin
            if (r_segment_open) begin
                o_flags.segment_valid = 1'b1;
                o_segment_start       = r_open_start;
                o_segment_end         = i_total_samples;
            end
            n_count           = '0;
            n_in_speech       = 1'b0;
            n_silence_start   = '0;
            n_silence_pending = 1'b0;
            n_split_end       = '0;
            n_split_valid     = 1'b0;
            n_resume_start    = '0;
            n_open_start      = '0;
            n_segment_open    = 1'b0;
        end else begin
            n_count                = count_next;
            o_flags.voice_detected = voice;
            if (voice) begin
                if (r_silence_pending) begin
                    n_silence_start   = '0;
                    n_silence_pending = 1'b0;
                    if (r_split_valid && resume_early) begin
                        n_resume_start = r_count;
                    end
                end
                if (!r_in_speech) begin
                    n_in_speech    = 1'b1;
                    n_open_start   = r_count;
                    n_segment_open = 1'b1;
                end
            end else if (r_in_speech && (seg_len > r_max_speech)) begin
                // Forced split of an overlong segment.
                o_flags.segment_valid = 1'b1;
                o_segment_start       = r_open_start;
                o_segment_end         = r_split_valid ? r_split_end : count_next;
                if (r_split_valid && !resume_early) begin
                    n_open_start   = r_resume_start;
                    n_segment_open = 1'b1;
                end else begin
                    n_in_speech    = 1'b0;
                    n_segment_open = 1'b0;
                    n_open_start   = '0;
                end
                n_split_end       = '0;
                n_split_valid     = 1'b0;
                n_resume_start    = '0;
                n_silence_start   = '0;
                n_silence_pending = 1'b0;
            end else if (silent && r_in_speech) begin
                n_silence_start   = sil_start;
                n_silence_pending = 1'b1;
                if (sil_len > r_long_silence) begin
                    n_split_end   = sil_start;
                    n_split_valid = 1'b1;
                end
                if ((sil_len >= r_min_silence) && (speech_len > r_min_speech)) begin
                    o_flags.segment_valid = 1'b1;
                    o_segment_start       = r_open_start;
                    o_segment_end         = sil_start;
                    n_split_end           = '0;
                    n_split_valid         = 1'b0;
                    n_resume_start        = '0;
                    n_silence_start       = '0;
                    n_silence_pending     = 1'b0;
                    n_in_speech           = 1'b0;
                    n_segment_open        = 1'b0;
                    n_open_start          = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count           <= '0;
            r_in_speech       <= 1'b0;
            r_silence_start   <= '0;
            r_silence_pending <= 1'b0;
            r_split_end       <= '0;
            r_split_valid     <= 1'b0;
            r_resume_start    <= '0;
            r_open_start      <= '0;
            r_segment_open    <= 1'b0;
        end else if (i_step) begin
            r_count           <= n_count;
            r_in_speech       <= n_in_speech;
            r_silence_start   <= n_silence_start;
            r_silence_pending <= n_silence_pending;
            r_split_end       <= n_split_end;
            r_split_valid     <= n_split_valid;
            r_resume_start    <= n_resume_start;
            r_open_start      <= n_open_start;
            r_segment_open    <= n_segment_open;
        end
    end

    // An open segment and the speech trigger always move together.
    a_open_tracks_speech: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_segment_open == r_in_speech)
        else $error("segment_open and in_speech disagree");

    // Silence and split bookkeeping only exist inside speech.
    a_pending_needs_speech: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_speech |-> (!r_split_valid && !r_silence_pending && r_open_start == '0))
        else $error("pending state outside speech");

    a_split_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_split_valid |-> (r_split_end == '0 && r_resume_start == '0))
        else $error("split point left behind without valid bit");

    a_silence_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_silence_pending |-> r_silence_start == '0)
        else $error("silence start left behind without pending bit");

endmodule

@@ hdl/voice_activity_segmenter.sv @@
// Top level of the voice activity segmenter with stream ports and result register.
//
// Input stream: one transaction per analysis window or end of stream. tuser carries
// the command (0 window, 1 end of stream); tdata carries the Q0.16 speech probability
// and the total audio length in samples. Every input transaction yields exactly one
// output transaction: tuser holds voice_detected and segment_valid, tdata holds the
// start and end sample of a finished segment (zero when none is reported).
// Configuration registers are written through i_cfg_we/i_cfg_addr/i_cfg_wdata while
// the stream is idle.
// An accepted input transaction is held in the input register and evaluated against
// the stream state; the result and the updated state are registered into the result
// register once that register is empty or being drained, and o_m_axis_tvalid then
// rises and holds until the result is taken.
// Throughput: one transaction per cycle while i_m_axis_tready stays high; the state
// update is a single pass of compares, adds and subtracts between the input register
// and the result register. A stalled receiver holds the result register; the input
// register still accepts one more transaction, after which o_s_axis_tready falls
// until the result drains. Reset (synchronous, active low) restores register
// defaults and clears the stream state and both pipeline registers' valid bits.
module voice_activity_segmenter #(
    parameter int TIME_BITS = vas_pkg::TIME_BITS_DEFAULT,
    parameter int PROB_BITS = vas_pkg::PROB_BITS_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vas_pkg::CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [((TIME_BITS > PROB_BITS) ? TIME_BITS : PROB_BITS)-1:0] i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // Fields from bit 0: speech_probability, total_samples, zero padding.
    input  logic [((PROB_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    // Fields from bit 0: command.
    input  logic                              i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // Fields from bit 0: segment_start, segment_end, zero padding.
    output logic [((2 * TIME_BITS + 7) / 8) * 8 - 1:0] o_m_axis_tdata,
    // Fields from bit 0: voice_detected, segment_valid.
    output vas_pkg::t_flags                   o_m_axis_tuser
);

    localparam int InDataBits  = ((PROB_BITS + TIME_BITS + 7) / 8) * 8;
    localparam int OutDataBits = ((2 * TIME_BITS + 7) / 8) * 8;
    localparam int CfgBits     = (TIME_BITS > PROB_BITS) ? TIME_BITS : PROB_BITS;

    logic                 r_in_valid;
    logic                 r_in_command;
    logic [PROB_BITS-1:0] r_in_prob;
    logic [TIME_BITS-1:0] r_in_total;

    logic                 r_out_valid;
    vas_pkg::t_flags      r_out_flags;
    logic [TIME_BITS-1:0] r_out_start;
    logic [TIME_BITS-1:0] r_out_end;

    vas_pkg::t_flags      core_flags;
    logic [TIME_BITS-1:0] core_start;
    logic [TIME_BITS-1:0] core_end;
    logic                 advance;
    logic                 in_take;

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_take         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_command <= i_s_axis_tuser;
            r_in_prob    <= i_s_axis_tdata[PROB_BITS-1:0];
            r_in_total   <= i_s_axis_tdata[PROB_BITS +: TIME_BITS];
        end
    end

    vas_core #(
        .TIME_BITS (TIME_BITS),
        .PROB_BITS (PROB_BITS),
        .CFG_BITS  (CfgBits)
    ) u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_addr           (i_cfg_addr),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_step               (advance),
        .i_command            (r_in_command),
        .i_speech_probability (r_in_prob),
        .i_total_samples      (r_in_total),
        .o_flags              (core_flags),
        .o_segment_start      (core_start),
        .o_segment_end        (core_end)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_flags <= core_flags;
            r_out_start <= core_start;
            r_out_end   <= core_end;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_flags;
    assign o_m_axis_tdata  = OutDataBits'({r_out_end, r_out_start});

endmodule
